[hw/rtl/oaids_pkg.sv]
// Shared constants and types for the ordered array block.
`default_nettype none
package oaids_pkg;
  localparam int CAPACITY = 64;
  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int DATA_W = 32;

  localparam logic [2:0] OP_APPEND = 3'd0;
  localparam logic [2:0] OP_INSERT = 3'd1;
  localparam logic [2:0] OP_DEL_IDX = 3'd2;
  localparam logic [2:0] OP_DEL_VAL = 3'd3;
  localparam logic [2:0] OP_SORT_UP = 3'd4;
  localparam logic [2:0] OP_SORT_DN = 3'd5;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE,
    S_INS_MV,
    S_INS_PUT,
    S_DEL_MV,
    S_DV_CHK,
    S_SI_LD,
    S_SJ,
    S_SI_WB,
    S_OUT_RD,
    S_OUT_LD,
    S_OUT_HOLD
  } state_t;

  typedef struct packed {
    logic                  we;
    logic [IDX_W-1:0]      waddr;
    logic [DATA_W-1:0]     wdata;
    logic                  re;
    logic [IDX_W-1:0]      raddr;
  } mem_ctrl_t;
endpackage
`default_nettype wire

[hw/rtl/oaids_ram.sv]
// Element store: one write port, one registered read port.
`default_nettype none
module oaids_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule
`default_nettype wire

[hw/rtl/ordered_array_insert_delete_sort.sv]
// Top level: sequencer for insert, delete, exchange sort and readout of the array.
// One request is taken at a time. Append writes straight from idle, insert at an index
// moves each later element up one slot and then writes the value, delete at an index
// moves each later element down one slot, delete value checks every element in turn,
// and a sort does one compare-swap per cycle on the single read port. Readout then
// steps each element through S_OUT_RD, S_OUT_LD and S_OUT_HOLD and its output stalls.
`default_nettype none
module ordered_array_insert_delete_sort (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [2:0]  op,
  input  wire logic [6:0]  position_in,
  input  wire logic signed [31:0] operand_value,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [5:0]       slot,
  output logic signed [31:0] element,
  output logic             has_element,
  output logic [6:0]       fill_count,
  output logic [1:0]       status,
  output logic [6:0]       removed_count,
  output logic             last
);
  localparam int CW = oaids_pkg::CNT_W;
  localparam int IW = oaids_pkg::IDX_W;

  oaids_pkg::state_t state, state_next;
  oaids_pkg::mem_ctrl_t mc;
  logic [CW-1:0] cnt, r, k, j, pos_q, removed_q;
  logic [1:0] status_q;
  logic desc;
  logic signed [31:0] a, val_q, rd;
  logic last_q;
  logic [CW-1:0] cnt_m1, cnt_m2, r_p1, r_m1, j_p1, pos_p1;
  logic full, swap, keep;

  assign cnt_m1 = cnt - CW'(1);
  assign cnt_m2 = cnt - CW'(2);
  assign r_p1 = r + CW'(1);
  assign r_m1 = r - CW'(1);
  assign j_p1 = j + CW'(1);
  assign pos_p1 = position_in + CW'(1);
  assign full = (cnt == CW'(oaids_pkg::CAPACITY));
  assign swap = desc ? (a < rd) : (a > rd);
  assign keep = (rd != val_q);

  oaids_ram #(.DEPTH(oaids_pkg::CAPACITY), .WIDTH(oaids_pkg::DATA_W)) u_ram (
    .clk(clk), .we(mc.we), .waddr(mc.waddr), .wdata(mc.wdata),
    .re(mc.re), .raddr(mc.raddr), .rdata(rd)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      oaids_pkg::S_IDLE: begin
        if (in_valid) begin
          unique case (op)
            oaids_pkg::OP_INSERT: begin
              state_next = (full || position_in >= cnt) ? oaids_pkg::S_OUT_RD
                                                         : oaids_pkg::S_INS_MV;
            end
            oaids_pkg::OP_DEL_IDX: begin
              state_next = (position_in >= cnt_m1 || cnt == '0) ? oaids_pkg::S_OUT_RD
                                                                 : oaids_pkg::S_DEL_MV;
            end
            oaids_pkg::OP_DEL_VAL: begin
              state_next = (cnt == '0) ? oaids_pkg::S_OUT_RD : oaids_pkg::S_DV_CHK;
            end
            oaids_pkg::OP_SORT_UP, oaids_pkg::OP_SORT_DN: begin
              state_next = (cnt < CW'(2)) ? oaids_pkg::S_OUT_RD : oaids_pkg::S_SI_LD;
            end
            default: state_next = oaids_pkg::S_OUT_RD;
          endcase
        end
      end
      oaids_pkg::S_INS_MV: if (r == pos_q) state_next = oaids_pkg::S_INS_PUT;
      oaids_pkg::S_INS_PUT: state_next = oaids_pkg::S_OUT_RD;
      oaids_pkg::S_DEL_MV: if (r == cnt_m1) state_next = oaids_pkg::S_OUT_RD;
      oaids_pkg::S_DV_CHK: if (r == cnt_m1) state_next = oaids_pkg::S_OUT_RD;
      oaids_pkg::S_SI_LD: state_next = oaids_pkg::S_SJ;
      oaids_pkg::S_SJ: if (j == cnt_m1) state_next = oaids_pkg::S_SI_WB;
      oaids_pkg::S_SI_WB: begin
        state_next = (r == cnt_m2) ? oaids_pkg::S_OUT_RD : oaids_pkg::S_SI_LD;
      end
      oaids_pkg::S_OUT_RD: state_next = oaids_pkg::S_OUT_LD;
      oaids_pkg::S_OUT_LD: state_next = oaids_pkg::S_OUT_HOLD;
      oaids_pkg::S_OUT_HOLD: begin
        if (out_ready) state_next = last_q ? oaids_pkg::S_IDLE : oaids_pkg::S_OUT_RD;
      end
      default: state_next = oaids_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    mc = '0;
    in_ready = (state == oaids_pkg::S_IDLE);
    out_valid = (state == oaids_pkg::S_OUT_HOLD);
    unique case (state)
      oaids_pkg::S_IDLE: begin
        mc.re = 1'b1;
        mc.raddr = (op == oaids_pkg::OP_INSERT) ? cnt_m1[IW-1:0] :
                   (op == oaids_pkg::OP_DEL_IDX) ? pos_p1[IW-1:0] : '0;
        mc.we = in_valid && !full &&
                (op == oaids_pkg::OP_APPEND ||
                 (op == oaids_pkg::OP_INSERT && position_in == cnt));
        mc.waddr = cnt[IW-1:0];
        mc.wdata = operand_value;
      end
      oaids_pkg::S_INS_MV: begin
        mc.we = 1'b1;
        mc.waddr = r_p1[IW-1:0];
        mc.wdata = rd;
        mc.re = 1'b1;
        mc.raddr = r_m1[IW-1:0];
      end
      oaids_pkg::S_INS_PUT: begin
        mc.we = 1'b1;
        mc.waddr = pos_q[IW-1:0];
        mc.wdata = val_q;
      end
      oaids_pkg::S_DEL_MV: begin
        mc.we = 1'b1;
        mc.waddr = r_m1[IW-1:0];
        mc.wdata = rd;
        mc.re = 1'b1;
        mc.raddr = r_p1[IW-1:0];
      end
      oaids_pkg::S_DV_CHK: begin
        mc.we = keep;
        mc.waddr = k[IW-1:0];
        mc.wdata = rd;
        mc.re = 1'b1;
        mc.raddr = r_p1[IW-1:0];
      end
      oaids_pkg::S_SI_LD: begin
        mc.re = 1'b1;
        mc.raddr = r_p1[IW-1:0];
      end
      oaids_pkg::S_SJ: begin
        mc.we = swap;
        mc.waddr = j[IW-1:0];
        mc.wdata = a;
        mc.re = 1'b1;
        mc.raddr = j_p1[IW-1:0];
      end
      oaids_pkg::S_SI_WB: begin
        mc.we = 1'b1;
        mc.waddr = r[IW-1:0];
        mc.wdata = a;
        mc.re = 1'b1;
        mc.raddr = r_p1[IW-1:0];
      end
      oaids_pkg::S_OUT_RD: begin
        mc.re = 1'b1;
        mc.raddr = r[IW-1:0];
      end
      default: mc = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= oaids_pkg::S_IDLE;
      cnt <= '0;
    end else begin
      state <= state_next;
      unique case (state)
        oaids_pkg::S_IDLE: begin
          if (in_valid) begin
            pos_q <= position_in;
            val_q <= operand_value;
            status_q <= oaids_pkg::ST_OK;
            removed_q <= '0;
            r <= '0;
            k <= '0;
            desc <= (op == oaids_pkg::OP_SORT_DN);
            unique case (op)
              oaids_pkg::OP_APPEND: begin
                if (full) status_q <= oaids_pkg::ST_FULL;
                else cnt <= cnt + CW'(1);
              end
              oaids_pkg::OP_INSERT: begin
                if (full) status_q <= oaids_pkg::ST_FULL;
                else if (position_in > cnt) status_q <= oaids_pkg::ST_RANGE;
                else if (position_in == cnt) cnt <= cnt + CW'(1);
                else r <= cnt_m1;
              end
              oaids_pkg::OP_DEL_IDX: begin
                if (position_in >= cnt) status_q <= oaids_pkg::ST_RANGE;
                else if (position_in == cnt_m1) cnt <= cnt_m1;
                else r <= pos_p1;
              end
              default: ;
            endcase
          end
        end
        oaids_pkg::S_INS_MV: if (r != pos_q) r <= r_m1;
        oaids_pkg::S_INS_PUT: begin
          cnt <= cnt + CW'(1);
          r <= '0;
        end
        oaids_pkg::S_DEL_MV: begin
          if (r == cnt_m1) begin
            cnt <= cnt_m1;
            r <= '0;
          end else begin
            r <= r_p1;
          end
        end
        oaids_pkg::S_DV_CHK: begin
          if (keep) k <= k + CW'(1);
          else removed_q <= removed_q + CW'(1);
          if (r == cnt_m1) begin
            cnt <= keep ? k + CW'(1) : k;
            r <= '0;
          end else begin
            r <= r_p1;
          end
        end
        oaids_pkg::S_SI_LD: begin
          a <= rd;
          j <= r_p1;
        end
        oaids_pkg::S_SJ: begin
          if (swap) a <= rd;
          if (j != cnt_m1) j <= j_p1;
        end
        oaids_pkg::S_SI_WB: r <= (r == cnt_m2) ? '0 : r_p1;
        oaids_pkg::S_OUT_LD: begin
          slot <= r[IW-1:0];
          element <= (cnt == '0) ? '0 : rd;
          has_element <= (cnt != '0);
          last_q <= (cnt == '0) || (r == cnt_m1);
        end
        oaids_pkg::S_OUT_HOLD: if (out_ready && !last_q) r <= r_p1;
        default: ;
      endcase
    end
  end

  assign fill_count = cnt;
  assign status = status_q;
  assign removed_count = removed_q;
  assign last = last_q;

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    cnt <= CW'(oaids_pkg::CAPACITY)) else $error("count past capacity");
  a_one_side: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid)) else $error("input and output open together");
  a_empty_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && !has_element |-> last && fill_count == '0) else $error("bad empty word");
  a_back_idle: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && last |=> in_ready) else $error("no return to idle");
endmodule
`default_nettype wire
